>>> rtl/core/pdma_pkg.sv
`default_nettype none

package pdma_pkg;

  localparam int DEVICE_BITS = 6;
  localparam int CFG_BITS = 9;
  localparam logic [CFG_BITS-1:0] WINDOW_RESET = 9'd8;

  // quotient bits resolved per divider cycle
  localparam int DIV_STEP = 4;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_READ   = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_DIVIDE = 4'b1000
  } state_t;

endpackage

`default_nettype wire

>>> rtl/core/per_device_moving_average.sv
`default_nettype none

// channel   direction  handshake                     payload
// in        input      in_valid / in_ready           device, sample_good, sample_value,
//                                                    source_time, receive_time
// out       output     out_valid / out_ready         result_device, average,
//                                                    result_source_time, result_receive_time
// config    input      window_length_write           window_length
//
// a dropped transaction is taken in idle and leaves no state. a stored sample without
// result passes the read and update states after the device state memory read, and a
// sample with a result also the divide state, which runs the iterative divider.
// rst and every window_length write clear the per-device valid bits, except that a write
// during an update leaves that device's bit set. a waiting result does not block the next
// transaction; only the divider's final load waits for the output register to be free.

module per_device_moving_average #(
  parameter int DEVICE_COUNT = 64,
  parameter int MAX_WINDOW   = 256,
  parameter int SAMPLE_BITS  = 16
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  window_length_write,
  input  wire  [pdma_pkg::CFG_BITS-1:0]        window_length,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire  [pdma_pkg::DEVICE_BITS-1:0]     device,
  input  wire                                  sample_good,
  input  wire  signed [SAMPLE_BITS-1:0]        sample_value,
  input  wire  [63:0]                          source_time,
  input  wire  [63:0]                          receive_time,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [pdma_pkg::DEVICE_BITS-1:0]     result_device,
  output logic signed [SAMPLE_BITS-1:0]        average,
  output logic [63:0]                          result_source_time,
  output logic [63:0]                          result_receive_time
);

  localparam int DEV_W     = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;
  localparam int POS_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WIN_W     = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W     = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int ST_W      = WIN_W + POS_W + SUM_W;
  localparam int SMP_DEPTH = DEVICE_COUNT * (1 << POS_W);
  localparam int DIV_ITERS = (SUM_W + pdma_pkg::DIV_STEP - 1) / pdma_pkg::DIV_STEP;
  localparam int Q_W       = DIV_ITERS * pdma_pkg::DIV_STEP;
  localparam int CNT_W     = $clog2(DIV_ITERS + 1);
  localparam int DEVX_W    = DEV_W + pdma_pkg::DEVICE_BITS;

  function automatic logic [WIN_W-1:0] clamp_window(input logic [pdma_pkg::CFG_BITS-1:0] v);
    logic [WIN_W-1:0] w;
    if (v == '0) begin
      w = WIN_W'(1);
    end else if (32'(v) > MAX_WINDOW) begin
      w = WIN_W'(MAX_WINDOW);
    end else begin
      w = WIN_W'(v);
    end
    return w;
  endfunction

  pdma_pkg::state_t state;

  logic [WIN_W-1:0]                w_eff;
  logic [DEVICE_COUNT-1:0]         dev_vld;
  logic [ST_W-1:0]                 st_mem [DEVICE_COUNT];
  logic signed [SAMPLE_BITS-1:0]   smp_mem [SMP_DEPTH];

  logic [ST_W-1:0]                 st_rd;
  logic                            st_vld_q;
  logic signed [SAMPLE_BITS-1:0]   smp_rd;

  logic [DEV_W-1:0]                dev_q;
  logic [pdma_pkg::DEVICE_BITS-1:0] dev_raw_q;
  logic signed [SAMPLE_BITS-1:0]   value_q;
  logic [63:0]                     src_q;
  logic [63:0]                     rcv_q;
  logic [WIN_W-1:0]                fill_q;
  logic [POS_W-1:0]                pos_q;
  logic signed [SUM_W-1:0]         sum_q;

  logic [Q_W-1:0]                  div_q;
  logic [WIN_W:0]                  div_r;
  logic                            div_neg;
  logic [CNT_W-1:0]                div_cnt;

  logic [DEVX_W-1:0]               dev_ext;
  logic [DEV_W-1:0]                dev_idx;
  logic                            in_take;
  logic                            item_ok;

  logic [WIN_W-1:0]                fill_rd;
  logic [POS_W-1:0]                pos_rd;
  logic signed [SUM_W-1:0]         sum_rd;
  logic [POS_W-1:0]                pos_eff;

  logic                            full_old;
  logic signed [SUM_W-1:0]         sum_new;
  logic [WIN_W-1:0]                pos_inc;
  logic [POS_W-1:0]                pos_new;
  logic [WIN_W-1:0]                fill_new;
  logic [SUM_W-1:0]                sum_mag;

  logic [Q_W-1:0]                  div_q_next;
  logic [WIN_W:0]                  div_r_next;
  logic [Q_W-1:0]                  q_signed;
  logic                            out_load;

  assign in_ready = (state == pdma_pkg::ST_IDLE);
  assign in_take  = in_valid && in_ready;
  assign dev_ext  = DEVX_W'(device);
  assign dev_idx  = dev_ext[DEV_W-1:0];
  assign item_ok  = sample_good && (32'(device) < DEVICE_COUNT);

  // state entry as read, empty when not valid since the last clear
  assign fill_rd = st_vld_q ? st_rd[ST_W-1 -: WIN_W] : '0;
  assign pos_rd  = st_vld_q ? st_rd[SUM_W +: POS_W] : '0;
  assign sum_rd  = st_vld_q ? st_rd[SUM_W-1:0] : '0;
  assign pos_eff = (WIN_W'(pos_rd) >= w_eff) ? '0 : pos_rd;

  assign full_old = (fill_q >= w_eff);
  assign sum_new  = sum_q - (full_old ? SUM_W'(smp_rd) : '0) + SUM_W'(value_q);
  assign pos_inc  = WIN_W'(pos_q) + WIN_W'(1);
  assign pos_new  = (pos_inc == w_eff) ? '0 : pos_inc[POS_W-1:0];
  assign fill_new = full_old ? fill_q : fill_q + WIN_W'(1);
  assign sum_mag  = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);

  always_comb begin
    logic [WIN_W:0] r_sh;
    logic [WIN_W:0] r;
    logic [Q_W-1:0] q;
    r = div_r;
    q = div_q;
    for (int i = 0; i < pdma_pkg::DIV_STEP; i++) begin
      r_sh = {r[WIN_W-1:0], q[Q_W-1]};
      q = {q[Q_W-2:0], 1'b0};
      if (r_sh >= {1'b0, w_eff}) begin
        r_sh = r_sh - {1'b0, w_eff};
        q[0] = 1'b1;
      end
      r = r_sh;
    end
    div_q_next = q;
    div_r_next = r;
  end

  assign q_signed = div_neg ? (~div_q + Q_W'(1)) : div_q;
  assign out_load = (state == pdma_pkg::ST_DIVIDE) && (div_cnt == CNT_W'(DIV_ITERS))
                    && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pdma_pkg::ST_IDLE;
      w_eff     <= clamp_window(pdma_pkg::WINDOW_RESET);
      dev_vld   <= '0;
      out_valid <= 1'b0;
      div_cnt   <= '0;
    end else begin
      if (window_length_write) begin
        w_eff   <= clamp_window(window_length);
        dev_vld <= '0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        pdma_pkg::ST_IDLE: begin
          if (in_take && item_ok) begin
            state <= pdma_pkg::ST_READ;
          end
        end
        pdma_pkg::ST_READ: begin
          state <= pdma_pkg::ST_UPDATE;
        end
        pdma_pkg::ST_UPDATE: begin
          dev_vld[dev_q] <= 1'b1;
          div_cnt <= '0;
          if (fill_new >= w_eff) begin
            state <= pdma_pkg::ST_DIVIDE;
          end else begin
            state <= pdma_pkg::ST_IDLE;
          end
        end
        pdma_pkg::ST_DIVIDE: begin
          if (div_cnt != CNT_W'(DIV_ITERS)) begin
            div_cnt <= div_cnt + CNT_W'(1);
          end else if (out_load) begin
            state <= pdma_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= pdma_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (in_take) begin
      st_rd <= st_mem[dev_idx];
    end
    if (state == pdma_pkg::ST_READ) begin
      smp_rd <= smp_mem[{dev_q, pos_eff}];
    end
    if (state == pdma_pkg::ST_UPDATE) begin
      smp_mem[{dev_q, pos_q}] <= value_q;
      st_mem[dev_q] <= {fill_new, pos_new, sum_new};
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      st_vld_q  <= dev_vld[dev_idx];
      dev_q     <= dev_idx;
      dev_raw_q <= device;
      value_q   <= sample_value;
      src_q     <= source_time;
      rcv_q     <= receive_time;
    end
    if (state == pdma_pkg::ST_READ) begin
      fill_q <= fill_rd;
      pos_q  <= pos_eff;
      sum_q  <= sum_rd;
    end
    if (state == pdma_pkg::ST_UPDATE) begin
      div_q   <= Q_W'(sum_mag);
      div_r   <= '0;
      div_neg <= sum_new[SUM_W-1];
    end else if ((state == pdma_pkg::ST_DIVIDE) && (div_cnt != CNT_W'(DIV_ITERS))) begin
      div_q <= div_q_next;
      div_r <= div_r_next;
    end
    if (out_load) begin
      result_device       <= dev_raw_q;
      average             <= q_signed[SAMPLE_BITS-1:0];
      result_source_time  <= src_q;
      result_receive_time <= rcv_q;
    end
  end

endmodule

`default_nettype wire
